>>> hw/rtl/neighbor_table_cam_defines.svh
// Assertion macros for the neighbor table block.
// No dependencies; included by files that carry concurrent checks.
`ifndef NEIGHBOR_TABLE_CAM_DEFINES_SVH
`define NEIGHBOR_TABLE_CAM_DEFINES_SVH
`ifndef SYNTH
`define NTC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NTC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NTC_ASSERT(label, clk, rst, prop, msg)
`define NTC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> hw/rtl/ntc_pkg.sv
// Package for the neighbor table: request kinds, status codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package ntc_pkg;
  localparam int ENTRIES_DEF  = 32;
  localparam int SESSIONS_DEF = 8;
  localparam int KEY_BITS_DEF = 64;
  localparam int SESS_W = 3;
  localparam int LONG_W = 64;
  localparam int SHORT_W = 16;
  localparam int KEYIN_W = 64;
  localparam int PAY_W = 32;
  localparam int META_W = 16;
  localparam int SLOT_W = 5;

  typedef enum logic [2:0] {
    K_INSERT = 3'd0, K_UPDATE = 3'd1, K_DELETE = 3'd2, K_SETMETA = 3'd3,
    K_FLONG = 3'd4, K_FSHORT = 3'd5, K_FKEY = 3'd6, K_CLEAR = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_MISS = 2'd1, ST_FULL = 2'd2, ST_UNKNOWN = 2'd3
  } status_t;

  // match flags registered by each cell and read by the scanner
  typedef struct packed {
    logic hit_long;
    logic hit_short;
    logic hit_key;
    logic hit_free;
  } flags_t;
endpackage

>>> hw/rtl/neighbor_table_cam.sv
// Top level of the neighbor table: sequencer, cell row and result register.
// Depends on ntc_pkg, ntc_cell, ntc_scan and neighbor_table_cam_defines.svh.
`timescale 1ns / 1ps
`include "neighbor_table_cam_defines.svh"
//
// Neighbor table with per-session visibility.
// Command channel: drive the request fields with start high while busy is
// low; that edge accepts the item. busy stays high until the result goes out.
// Result channel: done is high for exactly one cycle with status, slot and
// the found_* fields; the receiver cannot stall, it must take it then.
// Flow per item: all cells compare in parallel and register their hit
// flags; then a scanner walks the slots one per cycle, lowest first,
// picking the first long, short, key and free slot; then the write is
// applied to the chosen cell and the result is built; then it is presented.
// A new item can be accepted in the cycle after done, not before: the block
// takes no new item while one is in flight.
// Reset empties the table (all valid bits clear) and returns to idle; entry
// contents are not cleared and are never read while their slot is free.
//
module neighbor_table_cam import ntc_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int SESSIONS = SESSIONS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic [SESS_W-1:0]  session,
  input  logic [LONG_W-1:0]  ext_addr,
  input  logic [SHORT_W-1:0] nwk_addr,
  input  logic [KEYIN_W-1:0] key_value,
  input  logic [PAY_W-1:0]   payload,
  input  logic [META_W-1:0]  metadata_handle,
  output logic               done,
  output logic [1:0]         status,
  output logic [SLOT_W-1:0]  slot,
  output logic [LONG_W-1:0]  found_long_address,
  output logic [SHORT_W-1:0] found_short_address,
  output logic [KEYIN_W-1:0] found_key,
  output logic [PAY_W-1:0]   found_payload,
  output logic [META_W-1:0]  found_metadata
);
  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_CMP = 5'b00010, S_SCAN = 5'b00100,
    S_APPLY = 5'b01000, S_OUT = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [IW-1:0] idx;

  // latched request
  kind_t             r_kind;
  logic [SESS_W-1:0] r_sess;
  logic [LONG_W-1:0] r_long;
  logic [SHORT_W-1:0] r_short;
  logic [KEY_BITS-1:0] r_key;
  logic [PAY_W-1:0]  r_pay;
  logic [META_W-1:0] r_meta;
  logic              sess_ok;

  flags_t            cflags [ENTRIES];
  logic              cvalid [ENTRIES];
  logic [LONG_W-1:0] c_long [ENTRIES];
  logic [SHORT_W-1:0] c_short [ENTRIES];
  logic [KEY_BITS-1:0] c_key [ENTRIES];
  logic [PAY_W-1:0]  c_pay [ENTRIES];
  logic [META_W-1:0] c_meta [ENTRIES];

  flags_t seen;
  logic [IW-1:0] at_long, at_short, at_key, at_free;

  // apply-stage decisions
  logic              any_hit, do_apply;
  logic [IW-1:0]     hit_slot, tgt;
  logic [ENTRIES-1:0] sel;
  logic [1:0]        st;

  assign busy = state != S_IDLE;
  assign sess_ok = 32'(r_sess) < SESSIONS;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      r_kind  <= kind_t'(kind);
      r_sess  <= session;
      r_long  <= ext_addr;
      r_short <= nwk_addr;
      r_key   <= key_value[KEY_BITS-1:0];
      r_pay   <= payload;
      r_meta  <= metadata_handle;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_CMP;
      S_CMP:   state_next = S_SCAN;
      S_SCAN:  if (32'(idx) == ENTRIES - 1) state_next = S_APPLY;
      S_APPLY: state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) idx <= idx + 1'b1;
      else idx <= '0;
    end
  end

  // match priority: long, then short, then key
  always_comb begin
    any_hit = seen.hit_long || seen.hit_short || seen.hit_key;
    hit_slot = seen.hit_long ? at_long : (seen.hit_short ? at_short : at_key);
    st = ST_OK;
    tgt = hit_slot;
    do_apply = 1'b0;
    case (r_kind)
      K_INSERT: begin
        tgt = at_free;
        if (!sess_ok) st = ST_FULL;
        else if (any_hit) st = ST_MISS;
        else if (!seen.hit_free) st = ST_FULL;
        else do_apply = 1'b1;
      end
      K_UPDATE, K_DELETE, K_SETMETA: begin
        if (!any_hit) st = ST_MISS;
        else do_apply = 1'b1;
      end
      K_FLONG: begin
        tgt = at_long;
        if (!seen.hit_long) st = ST_UNKNOWN;
      end
      K_FSHORT: begin
        tgt = at_short;
        if (!seen.hit_short) st = ST_UNKNOWN;
      end
      K_FKEY: begin
        tgt = at_key;
        if (!seen.hit_key) st = ST_UNKNOWN;
      end
      default: ;
    endcase
    for (int i = 0; i < ENTRIES; i++) sel[i] = 32'(tgt) == i;
  end

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      logic ap;
      assign ap = state == S_APPLY && do_apply && sel[g];
      ntc_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk, .rst,
        .sess(r_sess), .ext_addr(r_long), .nwk_addr(r_short),
        .key_value(r_key), .sess_ok, .probe(state == S_CMP),
        .flags(cflags[g]),
        .wr_ins(ap && r_kind == K_INSERT),
        .wr_upd(ap && r_kind == K_UPDATE),
        .wr_meta(ap && r_kind == K_SETMETA),
        .wr_del(ap && r_kind == K_DELETE),
        .wr_clr(state == S_APPLY && r_kind == K_CLEAR),
        .payload(r_pay), .metadata_handle(r_meta),
        .valid(cvalid[g]), .e_long(c_long[g]), .e_short(c_short[g]),
        .e_key(c_key[g]), .e_pay(c_pay[g]), .e_meta(c_meta[g])
      );
    end
  endgenerate

  ntc_scan #(.ENTRIES(ENTRIES)) u_scan (
    .clk, .start_scan(state == S_CMP), .idx, .flag_in(cflags[idx]),
    .seen, .at_long, .at_short, .at_key, .at_free
  );

  // result register, shown for one cycle in S_OUT; slot wraps to its port width
  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      status <= st;
      slot <= (st == ST_OK && r_kind != K_CLEAR) ? SLOT_W'(tgt) : '0;
      found_long_address <= '0;
      found_short_address <= '0;
      found_key <= '0;
      found_payload <= '0;
      found_metadata <= '0;
      if (st == ST_OK && (r_kind inside {K_FLONG, K_FSHORT, K_FKEY})) begin
        found_long_address <= c_long[tgt];
        found_short_address <= c_short[tgt];
        found_key <= KEYIN_W'(c_key[tgt]);
        found_payload <= c_pay[tgt];
        found_metadata <= c_meta[tgt];
      end
    end
  end
  assign done = state == S_OUT;

  `NTC_ASSERT(a_done_busy, clk, rst, done |-> busy, "done outside busy")
  `NTC_ASSERT(a_done_once, clk, rst, done |=> !done, "done held two cycles")
  `NTC_ASSERT(a_accept_seq, clk, rst, (start && !busy) |=> state == S_CMP,
              "accept did not start compare")
  `NTC_ASSERT(a_ins_free, clk, rst,
              (state == S_APPLY && do_apply && r_kind == K_INSERT)
              |-> !cvalid[at_free], "insert into used slot")
endmodule

>>> hw/rtl/ntc_cell.sv
// One table entry cell: stored entry plus its registered compare flags.
// Depends on ntc_pkg.
`timescale 1ns / 1ps
module ntc_cell import ntc_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // probe broadcast to every cell
  input  logic [SESS_W-1:0]   sess,
  input  logic [LONG_W-1:0]   ext_addr,
  input  logic [SHORT_W-1:0]  nwk_addr,
  input  logic [KEY_BITS-1:0] key_value,
  input  logic                sess_ok,
  input  logic                probe,
  output flags_t              flags,
  // write commands
  input  logic                wr_ins,
  input  logic                wr_upd,
  input  logic                wr_meta,
  input  logic                wr_del,
  input  logic                wr_clr,
  input  logic [PAY_W-1:0]    payload,
  input  logic [META_W-1:0]   metadata_handle,
  output logic                valid,
  output logic [LONG_W-1:0]   e_long,
  output logic [SHORT_W-1:0]  e_short,
  output logic [KEY_BITS-1:0] e_key,
  output logic [PAY_W-1:0]    e_pay,
  output logic [META_W-1:0]   e_meta
);
  logic [SESS_W-1:0] owner;
  logic vis;

  assign vis = valid && owner == sess && sess_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      flags <= '0;
    end else begin
      if (probe) begin
        flags.hit_long  <= vis && e_long == ext_addr;
        flags.hit_short <= vis && e_short == nwk_addr;
        flags.hit_key   <= vis && e_key == key_value;
        flags.hit_free  <= !valid;
      end
      if (wr_ins) valid <= 1'b1;
      else if (wr_del || (wr_clr && vis)) valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ins) begin
      owner <= sess;
      e_meta <= '0;
    end
    if (wr_ins || wr_upd) begin
      e_long <= ext_addr;
      e_short <= nwk_addr;
      e_key <= key_value;
      e_pay <= payload;
    end
    if (wr_meta) e_meta <= metadata_handle;
  end
endmodule

>>> hw/rtl/ntc_scan.sv
// Serial priority scanner: walks the registered cell flags one slot a cycle.
// Depends on ntc_pkg.
`timescale 1ns / 1ps
module ntc_scan import ntc_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       start_scan,
  input  logic [$clog2(ENTRIES)-1:0] idx,
  input  flags_t                     flag_in,
  output flags_t                     seen,
  output logic [$clog2(ENTRIES)-1:0] at_long,
  output logic [$clog2(ENTRIES)-1:0] at_short,
  output logic [$clog2(ENTRIES)-1:0] at_key,
  output logic [$clog2(ENTRIES)-1:0] at_free
);
  // first hit of each kind wins, scanned from slot 0 upward
  always_ff @(posedge clk) begin
    if (start_scan) begin
      seen <= '0;
    end else begin
      if (flag_in.hit_long && !seen.hit_long) begin
        seen.hit_long <= 1'b1; at_long <= idx;
      end
      if (flag_in.hit_short && !seen.hit_short) begin
        seen.hit_short <= 1'b1; at_short <= idx;
      end
      if (flag_in.hit_key && !seen.hit_key) begin
        seen.hit_key <= 1'b1; at_key <= idx;
      end
      if (flag_in.hit_free && !seen.hit_free) begin
        seen.hit_free <= 1'b1; at_free <= idx;
      end
    end
  end
endmodule

>>> tb/sv/neighbor_table_cam_test.sv
// Self-checking bench for neighbor_table_cam: directed table, then random requests.
// Depends on ntc_pkg and the neighbor_table_cam RTL; every result is checked on its done strobe.
`timescale 1ns / 1ps

module neighbor_table_cam_test;
  import ntc_pkg::*;

  localparam int SLOTS = 32;
  localparam int IDLE_LIMIT = 2000;  // no accept and no done for this long: hung
  localparam int POOL = 48;

  typedef struct {
    kind_t              kind;
    logic [SESS_W-1:0]  sess;
    logic [LONG_W-1:0]  lng;
    logic [SHORT_W-1:0] shrt;
    logic [KEYIN_W-1:0] key;
    logic [PAY_W-1:0]   pay;
    logic [META_W-1:0]  meta;
  } request_t;

  typedef struct {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [LONG_W-1:0]  lng;
    logic [SHORT_W-1:0] shrt;
    logic [KEYIN_W-1:0] key;
    logic [PAY_W-1:0]   pay;
    logic [META_W-1:0]  meta;
  } answer_t;

  // directed row: typed == 1 means status/slot below are the answer, all found fields zero
  typedef struct {
    request_t req;
    bit       typed;
    status_t  status;
    int       slot;
  } row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         kind;
  logic [SESS_W-1:0]  session;
  logic [LONG_W-1:0]  ext_addr;
  logic [SHORT_W-1:0] nwk_addr;
  logic [KEYIN_W-1:0] key_value;
  logic [PAY_W-1:0]   payload;
  logic [META_W-1:0]  metadata_handle;
  logic               done;
  logic [1:0]         status;
  logic [SLOT_W-1:0]  slot;
  logic [LONG_W-1:0]  found_long_address;
  logic [SHORT_W-1:0] found_short_address;
  logic [KEYIN_W-1:0] found_key;
  logic [PAY_W-1:0]   found_payload;
  logic [META_W-1:0]  found_metadata;

  neighbor_table_cam uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .session(session),
    .ext_addr(ext_addr), .nwk_addr(nwk_addr), .key_value(key_value),
    .payload(payload), .metadata_handle(metadata_handle), .done(done), .status(status),
    .slot(slot), .found_long_address(found_long_address),
    .found_short_address(found_short_address), .found_key(found_key),
    .found_payload(found_payload), .found_metadata(found_metadata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the table
  // ---------------------------------------------------------------------------
  logic [SLOTS-1:0]   tbl_valid;
  logic [SESS_W-1:0]  tbl_owner [SLOTS];
  logic [LONG_W-1:0]  tbl_long  [SLOTS];
  logic [SHORT_W-1:0] tbl_short [SLOTS];
  logic [KEYIN_W-1:0] tbl_key   [SLOTS];
  logic [PAY_W-1:0]   tbl_pay   [SLOTS];
  logic [META_W-1:0]  tbl_meta  [SLOTS];

  answer_t pending_answers[$];
  int      mismatches;
  int      idle_cycles;
  int      items_sent;
  int      inserts_ok, table_full_hits, lookups_hit, clears_sent;

  // lowest visible slot matching on one field (0 long, 1 short, 2 key), or -1
  function automatic int lowest_match(int field, request_t r);
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_valid[i] || tbl_owner[i] != r.sess) continue;
      if (field == 0 && tbl_long[i] == r.lng) return i;
      if (field == 1 && tbl_short[i] == r.shrt) return i;
      if (field == 2 && tbl_key[i] == r.key) return i;
    end
    return -1;
  endfunction

  // priority match used by insert/update/delete/set-metadata: long, then short, then key
  function automatic int any_match(request_t r);
    int hit;
    hit = lowest_match(0, r);
    if (hit < 0) hit = lowest_match(1, r);
    if (hit < 0) hit = lowest_match(2, r);
    return hit;
  endfunction

  // applies one request to the shadow table and returns the answer the block must give
  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int hit;
    int free_slot;
    a = '{status: ST_OK, default: '0};
    case (r.kind)
      K_INSERT: begin
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!tbl_valid[i]) free_slot = i;
        if (any_match(r) >= 0) begin
          a.status = ST_MISS;
        end else if (free_slot < 0) begin
          a.status = ST_FULL;
          table_full_hits++;
        end else begin
          tbl_valid[free_slot] = 1'b1;
          tbl_owner[free_slot] = r.sess;
          tbl_long[free_slot]  = r.lng;
          tbl_short[free_slot] = r.shrt;
          tbl_key[free_slot]   = r.key;
          tbl_pay[free_slot]   = r.pay;
          tbl_meta[free_slot]  = '0;
          a.slot = SLOT_W'(free_slot);
          inserts_ok++;
        end
      end
      K_UPDATE, K_DELETE, K_SETMETA: begin
        hit = any_match(r);
        if (hit < 0) begin
          a.status = ST_MISS;
        end else begin
          a.slot = SLOT_W'(hit);
          if (r.kind == K_UPDATE) begin
            // owner and metadata survive an update
            tbl_long[hit]  = r.lng;
            tbl_short[hit] = r.shrt;
            tbl_key[hit]   = r.key;
            tbl_pay[hit]   = r.pay;
          end else if (r.kind == K_DELETE) begin
            tbl_valid[hit] = 1'b0;
          end else begin
            tbl_meta[hit] = r.meta;
          end
        end
      end
      K_FLONG, K_FSHORT, K_FKEY: begin
        hit = lowest_match(int'(r.kind) - int'(K_FLONG), r);
        if (hit < 0) begin
          a.status = ST_UNKNOWN;
        end else begin
          a.slot = SLOT_W'(hit);
          a.lng  = tbl_long[hit];
          a.shrt = tbl_short[hit];
          a.key  = tbl_key[hit];
          a.pay  = tbl_pay[hit];
          a.meta = tbl_meta[hit];
          lookups_hit++;
        end
      end
      default: begin
        // clear: drop every entry of the session, answer is always ok / slot 0
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i] && tbl_owner[i] == r.sess) tbl_valid[i] = 1'b0;
        clears_sent++;
      end
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 30)
      $display("%0t MISMATCH %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: done is a one-cycle strobe, no backpressure possible
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with nothing pending", {62'd0, status}, '0);
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
        if (found_long_address !== want.lng)
          report_mismatch("found_long_address", found_long_address, want.lng);
        if (found_short_address !== want.shrt)
          report_mismatch("found_short_address", found_short_address, want.shrt);
        if (found_key !== want.key) report_mismatch("found_key", found_key, want.key);
        if (found_payload !== want.pay)
          report_mismatch("found_payload", found_payload, want.pay);
        if (found_metadata !== want.meta)
          report_mismatch("found_metadata", found_metadata, want.meta);
      end
    end
  end

  // watchdog: any accept or result restarts the count
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver. Called at a rising edge; returns at the edge that accepted the item.
  // start is left high on return so a back-to-back item needs no toggle.
  // ---------------------------------------------------------------------------
  task automatic send_request(request_t r, int gap, bit typed, answer_t typed_answer);
    answer_t a;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    kind            <= r.kind;
    session         <= r.sess;
    ext_addr        <= r.lng;
    nwk_addr        <= r.shrt;
    key_value       <= r.key;
    payload         <= r.pay;
    metadata_handle <= r.meta;
    do @(posedge clk); while (busy);
    a = apply_request(r);  // shadow table advances even on typed rows
    pending_answers.push_back(typed ? typed_answer : a);
    items_sent++;
  endtask

  task automatic wait_all_answered();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random content: values come from shared pools so that matches, duplicates
  // and a full table actually happen; a share stays fully random for bit coverage.
  // ---------------------------------------------------------------------------
  logic [LONG_W-1:0]  long_pool  [POOL];
  logic [SHORT_W-1:0] short_pool [POOL];
  logic [KEYIN_W-1:0] key_pool   [POOL];

  function automatic request_t random_request(bit fill_phase);
    request_t r;
    int pick, idx;
    idx = $urandom_range(0, POOL - 1);
    pick = $urandom_range(0, 99);
    if (fill_phase)
      r.kind = (pick < 80) ? K_INSERT : kind_t'($urandom_range(1, 6));
    else if (pick < 25) r.kind = K_INSERT;
    else if (pick < 35) r.kind = K_UPDATE;
    else if (pick < 45) r.kind = K_DELETE;
    else if (pick < 55) r.kind = K_SETMETA;
    else if (pick < 69) r.kind = K_FLONG;
    else if (pick < 83) r.kind = K_FSHORT;
    else if (pick < 97) r.kind = K_FKEY;
    else r.kind = K_CLEAR;
    r.sess = SESS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) :
                     $urandom_range(0, 2));
    // address and key fields mostly from the pool (short sometimes from another index), sometimes fresh
    r.lng  = ($urandom_range(0, 9) < 7) ? long_pool[idx] : {$urandom, $urandom};
    r.shrt = ($urandom_range(0, 9) < 7) ? short_pool[($urandom_range(0, 4) == 0) ?
             $urandom_range(0, POOL - 1) : idx] : 16'($urandom);
    r.key  = ($urandom_range(0, 9) < 7) ? key_pool[idx] : {$urandom, $urandom};
    r.pay  = $urandom;
    r.meta = ($urandom_range(0, 7) == 0) ? '0 : 16'($urandom);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed rows
  // ---------------------------------------------------------------------------
  localparam logic [63:0] ONES = '1;

  function automatic row_t mk(kind_t k, int s, logic [63:0] l, logic [15:0] sh,
                              logic [63:0] ky, logic [31:0] p, logic [15:0] m,
                              bit typed, status_t st, int sl);
    row_t row;
    row.req = '{kind: k, sess: SESS_W'(s), lng: l, shrt: sh, key: ky, pay: p, meta: m};
    row.typed = typed;
    row.status = st;
    row.slot = sl;
    return row;
  endfunction

  row_t directed_rows[$];

  initial begin
    answer_t typed_ans;
    int gap_max;

    start <= 1'b0;
    kind <= K_INSERT;
    session <= '0;
    ext_addr <= '0;
    nwk_addr <= '0;
    key_value <= '0;
    payload <= '0;
    metadata_handle <= '0;
    rst <= 1'b1;
    mismatches = 0;
    items_sent = 0;
    inserts_ok = 0;
    table_full_hits = 0;
    lookups_hit = 0;
    clears_sent = 0;
    tbl_valid = '0;
    for (int i = 0; i < POOL; i++) begin
      long_pool[i]  = {$urandom, $urandom};
      short_pool[i] = 16'($urandom);
      key_pool[i]   = {$urandom, $urandom};
    end

    // empty table: every lookup unknown, every modify a miss, clear always ok
    directed_rows.push_back(mk(K_FLONG,   0, ONES, 16'hffff, ONES, '1, '1, 1, ST_UNKNOWN, 0));
    directed_rows.push_back(mk(K_FSHORT,  7, '0, '0, '0, '0, '0, 1, ST_UNKNOWN, 0));
    directed_rows.push_back(mk(K_FKEY,    3, '0, '0, '0, '0, '0, 1, ST_UNKNOWN, 0));
    directed_rows.push_back(mk(K_UPDATE,  0, ONES, 16'hffff, ONES, '1, '0, 1, ST_MISS, 0));
    directed_rows.push_back(mk(K_DELETE,  0, '0, '0, '0, '0, '0, 1, ST_MISS, 0));
    directed_rows.push_back(mk(K_SETMETA, 7, ONES, '0, '0, '0, '1, 1, ST_MISS, 0));
    directed_rows.push_back(mk(K_CLEAR,   0, '0, '0, '0, '0, '0, 1, ST_OK, 0));
    // inserts: lowest free slot, duplicate in same session refused, other session allowed
    directed_rows.push_back(mk(K_INSERT,  0, ONES, 16'hffff, ONES, '1, '1, 1, ST_OK, 0));
    directed_rows.push_back(mk(K_INSERT,  0, ONES, 16'h0001, 64'h5, '0, '0, 1, ST_MISS, 0));
    directed_rows.push_back(mk(K_INSERT,  7, '0, '0, '0, '0, '0, 1, ST_OK, 1));
    directed_rows.push_back(mk(K_INSERT,  1, ONES, 16'hffff, ONES, 32'h5a5a, '0, 1, ST_OK, 2));
    // duplicate caught only by short address, then only by key
    directed_rows.push_back(mk(K_INSERT,  7, 64'h1, '0, 64'h2, '0, '0, 1, ST_MISS, 0));
    directed_rows.push_back(mk(K_INSERT,  7, 64'h1, 16'h3, '0, '0, '0, 1, ST_MISS, 0));
    directed_rows.push_back(mk(K_SETMETA, 0, ONES, '0, '0, '0, 16'hffff, 1, ST_OK, 0));
    directed_rows.push_back(mk(K_FLONG,   0, ONES, '0, '0, '0, '0, 0, ST_OK, 0));
    directed_rows.push_back(mk(K_FSHORT,  7, '1, '0, '1, '0, '0, 0, ST_OK, 0));
    directed_rows.push_back(mk(K_FKEY,    1, '0, '0, ONES, '0, '0, 0, ST_OK, 0));
    // update matched by short address keeps owner and metadata
    directed_rows.push_back(mk(K_UPDATE,  0, 64'h1234, 16'hffff, 64'h77, 32'h1, '0, 0, ST_OK, 0));
    directed_rows.push_back(mk(K_FSHORT,  0, '0, 16'hffff, '0, '0, '0, 0, ST_OK, 0));
    directed_rows.push_back(mk(K_DELETE,  7, 64'h9, 16'h9, '0, '0, '0, 1, ST_OK, 1));
    directed_rows.push_back(mk(K_INSERT,  3, 64'h8, 16'h8, 64'h8, '1, '0, 1, ST_OK, 1));
    directed_rows.push_back(mk(K_SETMETA, 3, 64'h8, '0, '0, '0, '0, 1, ST_OK, 1));
    directed_rows.push_back(mk(K_CLEAR,   0, '0, '0, '0, '0, '0, 1, ST_OK, 0));
    directed_rows.push_back(mk(K_FLONG,   0, ONES, '0, '0, '0, '0, 1, ST_UNKNOWN, 0));
    directed_rows.push_back(mk(K_FKEY,    1, '0, '0, ONES, '0, '0, 0, ST_OK, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed_ans = '{status: directed_rows[i].status, slot: SLOT_W'(directed_rows[i].slot),
                    default: '0};
      send_request(directed_rows[i].req, $urandom_range(0, 3), directed_rows[i].typed,
                   typed_ans);
    end

    // fill phase: insert-heavy, drives the table to full and past it
    gap_max = 0;
    for (int n = 0; n < 400; n++) begin
      if (n % 50 == 0) gap_max = $urandom_range(0, 1) ? 12 : 0;
      send_request(random_request(1), $urandom_range(0, gap_max), 0,
                   '{status: ST_OK, default: '0});
    end

    // hold off until the table has answered everything in flight
    wait_all_answered();

    // mixed phase: modifies, lookups and occasional clears on a well-populated table
    for (int n = 0; n < 1100; n++) begin
      if (n % 50 == 0) gap_max = $urandom_range(0, 1) ? 12 : 0;
      send_request(random_request(0), $urandom_range(0, gap_max), 0,
                   '{status: ST_OK, default: '0});
    end

    wait_all_answered();
    repeat (SLOTS + 8) @(posedge clk);

    $display("covered %0d requests: %0d inserts placed, %0d refused on a full table,",
             items_sent, inserts_ok, table_full_hits);
    $display("%0d lookups that hit, %0d session clears", lookups_hit, clears_sent);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
